@@ rtl/wsts_pkg.sv @@
// wall slice texture setup: shared widths, constants and sideband types
// no dependencies
package wsts_pkg;

  localparam int unsigned DIST_W   = 24;
  localparam int unsigned DIR_W    = 21;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned START_W  = 9;
  localparam int unsigned END_W    = 16;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned STEP_W   = 24;

  localparam logic [HEIGHT_W-1:0] HEIGHT_SAT = '1;
  localparam logic [STEP_W-1:0]   STEP_SAT   = '1;

  localparam logic CFG_POS_X = 1'b0;
  localparam logic CFG_POS_Y = 1'b1;

  typedef struct packed {
    logic             sat;
    logic [COL_W-1:0] col;
  } height_sb_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [START_W-1:0]  start;
    logic [END_W-1:0]    stop;
    logic [COL_W-1:0]    col;
    logic [HEIGHT_W-1:0] rows;
    logic                step_sat;
  } row_sb_t;

endpackage

@@ rtl/wsts_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband
// no package dependencies
module wsts_div #(
  parameter int unsigned QW = 16,
  parameter int unsigned DW = 24,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_s  [QW+1];
  logic [DW-1:0] rem_s  [QW+1];
  logic [QW-1:0] num_s  [QW+1];
  logic [DW-1:0] den_s  [QW+1];
  logic [QW-1:0] quo_s  [QW+1];
  logic [SW-1:0] side_s [QW+1];

  assign vld_s[0]  = valid_i;
  assign rem_s[0]  = rem_i;
  assign num_s[0]  = num_i;
  assign den_s[0]  = den_i;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;

    assign trial = {rem_s[j], num_s[j][QW-1]};
    assign ge    = trial >= {1'b0, den_s[j]};
    assign diff  = trial - {1'b0, den_s[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[j+1] <= vld_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[j+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_s[j+1]  <= {num_s[j][QW-2:0], 1'b0};
        den_s[j+1]  <= den_s[j];
        quo_s[j+1]  <= {quo_s[j][QW-2:0], ge};
        side_s[j+1] <= side_s[j];
      end
    end
  end

  assign valid_o = vld_s[QW];
  assign quo_o   = quo_s[QW];
  assign side_o  = side_s[QW];

endmodule

@@ rtl/wsts_texcol.sv @@
// texture column: wall hit fraction, scale by texture width, mirroring
// depends on wsts_pkg
module wsts_texcol #(
  parameter int unsigned TEX_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [wsts_pkg::DIST_W-1:0]   dist_i,
  input  logic                          side_i,
  input  logic signed [wsts_pkg::DIR_W-1:0] dir_x_i,
  input  logic signed [wsts_pkg::DIR_W-1:0] dir_y_i,
  input  logic [wsts_pkg::DIST_W-1:0]   pos_x_i,
  input  logic [wsts_pkg::DIST_W-1:0]   pos_y_i,
  output logic                          valid_o,
  output logic [wsts_pkg::DIST_W-1:0]   dist_o,
  output logic [wsts_pkg::COL_W-1:0]    col_o
);
  import wsts_pkg::*;

  localparam int unsigned TWB = $clog2(TEX_WIDTH + 1);

  logic [3:0]         vld_q;
  logic [DIST_W-1:0]  dist_a_q, dist_b_q, dist_c_q, dist_d_q;
  logic [DIST_W-1:0]  pos_a_q, pos_b_q;
  logic               neg_a_q, neg_b_q;
  logic               mir_a_q, mir_b_q, mir_c_q;
  logic [DIR_W-1:0]   mag_a_q;
  logic [31:0]        prod_b_q, frac_c_q;
  logic [COL_W-1:0]   col_d_q;

  logic signed [DIR_W-1:0] dir_sel;
  logic [31:0]        sum_c;
  logic [31+TWB:0]    scaled;
  logic [TWB-1:0]     col_raw, col_mir;

  assign dir_sel = side_i ? dir_x_i : dir_y_i;
  assign sum_c   = neg_b_q ? ({pos_b_q[15:0], 16'h0000} - prod_b_q)
                           : ({pos_b_q[15:0], 16'h0000} + prod_b_q);
  assign scaled  = {{TWB{1'b0}}, frac_c_q} * (32 + TWB)'(TEX_WIDTH);
  assign col_raw = scaled[31+TWB:32];
  assign col_mir = TWB'(TEX_WIDTH - 1) - col_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // hit along y on an x face, along x on a y face
      dist_a_q <= dist_i;
      pos_a_q  <= side_i ? pos_x_i : pos_y_i;
      neg_a_q  <= dir_sel[DIR_W-1];
      mag_a_q  <= dir_sel[DIR_W-1] ? DIR_W'(-dir_sel) : dir_sel;
      mir_a_q  <= side_i ? dir_y_i[DIR_W-1]
                         : ((dir_x_i != '0) && !dir_x_i[DIR_W-1]);
      dist_b_q <= dist_a_q;
      pos_b_q  <= pos_a_q;
      neg_b_q  <= neg_a_q;
      mir_b_q  <= mir_a_q;
      prod_b_q <= 32'({{DIST_W{1'b0}}, mag_a_q} * {{DIR_W{1'b0}}, dist_a_q});
      dist_c_q <= dist_b_q;
      mir_c_q  <= mir_b_q;
      frac_c_q <= sum_c;
      dist_d_q <= dist_c_q;
      col_d_q  <= COL_W'(mir_c_q ? col_mir : col_raw);
    end
  end

  assign valid_o = vld_q[3];
  assign dist_o  = dist_d_q;
  assign col_o   = col_d_q;

endmodule

@@ rtl/wall_slice_texture_setup.sv @@
// wall slice texture setup top level: config registers, height and step
// dividers, row setup, texture start multiply; depends on wsts_pkg, wsts_div, wsts_texcol
//
// One column item enters per clock while no downstream stall holds the pipeline; the
// two dividers are bit-per-stage (16 stages for the wall height, 24
// for the texture step). The whole pipeline advances when the output register
// is empty or taken, so a downstream stall holds every stage in place.
module wall_slice_texture_setup #(
  parameter int unsigned SCREEN_HEIGHT = 512,
  parameter int unsigned TEX_WIDTH     = 64,
  parameter int unsigned TEX_HEIGHT    = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [wsts_pkg::DIST_W-1:0]         wall_dist_i,
  input  logic                                hit_side_i,
  input  logic signed [wsts_pkg::DIR_W-1:0]   ray_dir_x_i,
  input  logic signed [wsts_pkg::DIR_W-1:0]   ray_dir_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wsts_pkg::HEIGHT_W-1:0]       column_height_o,
  output logic [wsts_pkg::START_W-1:0]        draw_start_o,
  output logic [wsts_pkg::END_W-1:0]          draw_end_o,
  output logic [wsts_pkg::COL_W-1:0]          tex_column_o,
  output logic [wsts_pkg::STEP_W-1:0]         tex_step_o,
  output logic [wsts_pkg::STEP_W-1:0]         tex_start_o
);
  import wsts_pkg::*;

  localparam logic [DIST_W-1:0]   SCREEN_D    = DIST_W'(SCREEN_HEIGHT);
  localparam logic [HEIGHT_W-1:0] HALF_SCREEN = HEIGHT_W'(SCREEN_HEIGHT / 2);
  localparam logic [HEIGHT_W-1:0] TEX_HI      = HEIGHT_W'(TEX_HEIGHT / 256);
  localparam logic [STEP_W-1:0]   STEP_NUM    = STEP_W'((TEX_HEIGHT % 256) * 65536);
  localparam int unsigned HSB_W = $bits(height_sb_t);
  localparam int unsigned RSB_W = $bits(row_sb_t);

  logic              en;
  logic [DIST_W-1:0] pos_x_q, pos_y_q;

  assign pready     = 1'b1;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        CFG_POS_X: pos_x_q <= pwdata[DIST_W-1:0];
        CFG_POS_Y: pos_y_q <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_POS_X: prdata = {8'h00, pos_x_q};
      CFG_POS_Y: prdata = {8'h00, pos_y_q};
      default:   prdata = '0;
    endcase
  end

  // texture column
  logic              tc_vld;
  logic [DIST_W-1:0] tc_dist;
  logic [COL_W-1:0]  tc_col;

  wsts_texcol #(.TEX_WIDTH(TEX_WIDTH)) u_texcol (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .dist_i  (wall_dist_i),
    .side_i  (hit_side_i),
    .dir_x_i (ray_dir_x_i),
    .dir_y_i (ray_dir_y_i),
    .pos_x_i (pos_x_q),
    .pos_y_i (pos_y_q),
    .valid_o (tc_vld),
    .dist_o  (tc_dist),
    .col_o   (tc_col)
  );

  // wall height divider
  height_sb_t        hsb_in, hsb_out;
  logic              hd_vld;
  logic [HEIGHT_W-1:0] hd_quo;
  logic [HSB_W-1:0]  hd_side;

  assign hsb_in.sat = (tc_dist == '0) || (tc_dist <= SCREEN_D);
  assign hsb_in.col = tc_col;
  assign hsb_out    = height_sb_t'(hd_side);

  wsts_div #(.QW(HEIGHT_W), .DW(DIST_W), .SW(HSB_W)) u_div_height (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tc_vld),
    .rem_i   (hsb_in.sat ? '0 : SCREEN_D),
    .num_i   ('0),
    .den_i   (tc_dist),
    .side_i  (HSB_W'(hsb_in)),
    .valid_o (hd_vld),
    .quo_o   (hd_quo),
    .side_o  (hd_side)
  );

  // row setup
  logic [HEIGHT_W-1:0] height, half;
  logic                past_top;
  logic                rs_vld_q;
  row_sb_t             rs_q;

  assign height   = hsb_out.sat ? HEIGHT_SAT : hd_quo;
  assign half     = {1'b0, height[HEIGHT_W-1:1]};
  assign past_top = half >= HALF_SCREEN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_vld_q <= 1'b0;
    end else if (en) begin
      rs_vld_q <= hd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q.height   <= height;
      rs_q.start    <= past_top ? '0 : START_W'(HALF_SCREEN - half);
      rs_q.stop     <= HALF_SCREEN + half;
      rs_q.col      <= hsb_out.col;
      rs_q.rows     <= past_top ? (half - HALF_SCREEN) : '0;
      rs_q.step_sat <= (height == '0) || (TEX_HI >= height);
    end
  end

  // texture step divider
  logic              sd_vld;
  logic [STEP_W-1:0] sd_quo;
  logic [RSB_W-1:0]  sd_side;
  row_sb_t           rsb_out;

  assign rsb_out = row_sb_t'(sd_side);

  wsts_div #(.QW(STEP_W), .DW(HEIGHT_W), .SW(RSB_W)) u_div_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rs_vld_q),
    .rem_i   (rs_q.step_sat ? '0 : TEX_HI),
    .num_i   (STEP_NUM),
    .den_i   (rs_q.height),
    .side_i  (RSB_W'(rs_q)),
    .valid_o (sd_vld),
    .quo_o   (sd_quo),
    .side_o  (sd_side)
  );

  // texture start multiply and output register
  logic                       mu_vld_q;
  row_sb_t                    mu_q;
  logic [STEP_W-1:0]          mu_step_q;
  logic [HEIGHT_W+STEP_W-1:0] mu_prod_q;
  logic [STEP_W-1:0]          step;

  assign step = rsb_out.step_sat ? STEP_SAT : sd_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      mu_vld_q    <= sd_vld;
      out_valid_o <= mu_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_q      <= rsb_out;
      mu_step_q <= step;
      mu_prod_q <= {{STEP_W{1'b0}}, rsb_out.rows} * {{HEIGHT_W{1'b0}}, step};
      column_height_o <= mu_q.height;
      draw_start_o    <= mu_q.start;
      draw_end_o      <= mu_q.stop;
      tex_column_o    <= mu_q.col;
      tex_step_o      <= mu_step_q;
      tex_start_o     <= (mu_prod_q[HEIGHT_W+STEP_W-1:STEP_W] != '0) ? STEP_SAT
                                                                     : mu_prod_q[STEP_W-1:0];
    end
  end

  a_far_wall_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (column_height_o == '0) |-> (tex_step_o == STEP_SAT))
    else $error("zero height without saturated step");

  a_visible_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (draw_start_o != '0) |-> (tex_start_o == '0))
    else $error("unclamped slice with nonzero texture start");

  a_draw_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (draw_end_o == HALF_SCREEN + {1'b0, column_height_o[HEIGHT_W-1:1]}))
    else $error("draw end does not match height");

endmodule
